// ===== sv/eqtt_pkg.sv =====
// shared types and constants of the quantile threshold tracker
`default_nettype none

package eqtt_pkg;

  localparam int unsigned Q16_W = 17;
  localparam int unsigned PROD_W = 2 * Q16_W;
  localparam logic [Q16_W-1:0] Q16_ONE = 17'd65536;
  localparam logic [PROD_W-1:0] ROUND_HALF = 34'd32768;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned EDGE_SHIFT = 21;
  localparam int unsigned EDGE_SCALE = 2097152;
  localparam int unsigned THR_W = 15;
  localparam int unsigned BIN_OUT_W = 7;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0] REG_GAIN = 2'd0;
  localparam logic [1:0] REG_INIT = 2'd1;
  localparam logic [1:0] REG_TARGET = 2'd2;

  typedef struct packed {
    logic shift;
    logic fill;
  } cell_ctrl_t;

  typedef struct packed {
    logic start;
    logic shift;
    logic slot_valid;
    logic decay;
    logic hold;
  } upd_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/eqtt_cell.sv =====
// one bin estimate of the shift ring, with parallel fill
`default_nettype none

module eqtt_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire eqtt_pkg::cell_ctrl_t          ctrl_i,
  input  wire logic [eqtt_pkg::Q16_W-1:0]    fill_i,
  input  wire logic [eqtt_pkg::Q16_W-1:0]    est_i,
  output logic      [eqtt_pkg::Q16_W-1:0]    est_o
);

  logic [eqtt_pkg::Q16_W-1:0] est_q;
  logic [eqtt_pkg::Q16_W-1:0] est_d;

  always_comb begin
    est_d = est_q;
    if (ctrl_i.fill) begin
      est_d = fill_i;
    end else if (ctrl_i.shift) begin
      est_d = est_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
    end else begin
      est_q <= est_d;
    end
  end

  assign est_o = est_q;

endmodule

`default_nettype wire

// ===== sv/eqtt_update.sv =====
// two-stage estimate update at the ring head and the running threshold search
`default_nettype none

module eqtt_update #(
  parameter int unsigned NUM_BINS = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire eqtt_pkg::upd_ctrl_t                    ctrl_i,
  input  wire logic [$clog2(NUM_BINS+1)-1:0]          bin_i,
  input  wire logic [eqtt_pkg::Q16_W-1:0]             est_i,
  input  wire logic [eqtt_pkg::Q16_W-1:0]             gain_i,
  input  wire logic [eqtt_pkg::Q16_W-1:0]             target_i,
  output logic      [eqtt_pkg::Q16_W-1:0]             est_o,
  output logic                                        found_o,
  output logic      [$clog2(NUM_BINS+1)-1:0]          bin_o,
  output logic      [eqtt_pkg::THR_W-1:0]             thr_o
);

  localparam int unsigned CNT_W = $clog2(NUM_BINS + 1);
  localparam int unsigned DIV = NUM_BINS * 100;
  localparam int unsigned STEP_Q = eqtt_pkg::EDGE_SCALE / DIV;
  localparam int unsigned STEP_R = eqtt_pkg::EDGE_SCALE % DIV;
  localparam int unsigned REM_W = $clog2(DIV) + 1;
  localparam int unsigned W = eqtt_pkg::Q16_W;

  logic [W-1:0]                p_est_q;
  logic [eqtt_pkg::PROD_W-1:0] p_prod_q;
  logic                        p_decay_q;
  logic                        p_hold_q;
  logic                        p_valid_q;
  logic [CNT_W-1:0]            p_bin_q;

  logic                        found_q, found_d;
  logic [CNT_W-1:0]            res_bin_q, res_bin_d;
  logic [eqtt_pkg::THR_W-1:0]  thr_q, thr_d;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic [eqtt_pkg::THR_W-1:0]  res_thr_q, res_thr_d;

  logic [eqtt_pkg::PROD_W-1:0] prod_rnd;
  logic [W:0]                  dec;
  logic [W-1:0]                shrunk;
  logic [W:0]                  grown;
  logic [W-1:0]                est_new;
  logic [REM_W-1:0]            rem_sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      p_est_q   <= est_i;
      p_prod_q  <= eqtt_pkg::PROD_W'(est_i) * eqtt_pkg::PROD_W'(gain_i);
      p_decay_q <= ctrl_i.decay;
      p_hold_q  <= ctrl_i.hold;
      p_bin_q   <= bin_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (ctrl_i.start) begin
      p_valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      p_valid_q <= ctrl_i.slot_valid;
    end
  end

  // rounded decay, plus growth toward one with saturation unless decaying; hold keeps the estimate
  always_comb begin
    prod_rnd = p_prod_q + eqtt_pkg::ROUND_HALF;
    dec      = prod_rnd[eqtt_pkg::PROD_W-1:eqtt_pkg::FRAC_W];
    shrunk   = (dec <= {1'b0, p_est_q}) ? W'({1'b0, p_est_q} - dec) : '0;
    grown    = {1'b0, shrunk} + {1'b0, gain_i};
    if (p_hold_q) begin
      est_new = p_est_q;
    end else if (p_decay_q) begin
      est_new = shrunk;
    end else if (grown > {1'b0, eqtt_pkg::Q16_ONE}) begin
      est_new = eqtt_pkg::Q16_ONE;
    end else begin
      est_new = W'(grown);
    end
  end

  assign est_o = est_new;

  // threshold scale kept as quotient and remainder, stepped once per bin
  always_comb begin
    found_d   = found_q;
    res_bin_d = res_bin_q;
    res_thr_d = res_thr_q;
    thr_d     = thr_q;
    rem_d     = rem_q;
    rem_sum   = rem_q + REM_W'(STEP_R);
    if (ctrl_i.start) begin
      found_d = 1'b0;
      thr_d   = '0;
      rem_d   = '0;
    end else if (ctrl_i.shift && p_valid_q && !found_q) begin
      if (target_i < est_new) begin
        found_d   = 1'b1;
        res_bin_d = p_bin_q;
        res_thr_d = thr_q;
      end else if (rem_sum >= REM_W'(DIV)) begin
        rem_d = rem_sum - REM_W'(DIV);
        thr_d = thr_q + eqtt_pkg::THR_W'(STEP_Q + 1);
      end else begin
        rem_d = rem_sum;
        thr_d = thr_q + eqtt_pkg::THR_W'(STEP_Q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      thr_q   <= '0;
      rem_q   <= '0;
    end else begin
      found_q <= found_d;
      thr_q   <= thr_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_bin_q <= res_bin_d;
    res_thr_q <= res_thr_d;
  end

  assign found_o = found_q;
  assign bin_o   = found_q ? res_bin_q : CNT_W'(NUM_BINS);
  assign thr_o   = found_q ? res_thr_q : thr_q;

endmodule

`default_nettype wire

// ===== sv/ema_quantile_threshold_tracker.sv =====
// top level: config registers, bin ring of cells, update unit and item control
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_ready    cmd_i, sample_q16_i
//  out      out  out_valid/out_ready  threshold_bin_o, threshold_q16_o
//  cfg      in   apb psel/penable     paddr, pwdata, prdata
//
// an item runs through the accept cycle, then the shifts that rotate the ring
// once through the two-stage update unit at its head, then the load of the
// output register.
// reset clears every bin to zero and restores the register defaults.
// a new item is taken once the ring pass is done and the result has a place
// in the output register; a stalled output holds the finished result.
`default_nettype none

module ema_quantile_threshold_tracker #(
  parameter int unsigned NUM_BINS = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               cmd_i,
  input  wire logic [eqtt_pkg::Q16_W-1:0]         sample_q16_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [eqtt_pkg::BIN_OUT_W-1:0]     threshold_bin_o,
  output logic      [eqtt_pkg::THR_W-1:0]         threshold_q16_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [eqtt_pkg::ADDR_W-1:0]        paddr,
  input  wire logic [eqtt_pkg::DATA_W-1:0]        pwdata,
  output logic      [eqtt_pkg::DATA_W-1:0]        prdata,
  output logic                                    pready
);

  localparam int unsigned W = eqtt_pkg::Q16_W;
  localparam int unsigned CNT_W = $clog2(NUM_BINS + 1);
  localparam int unsigned LHS_SCALE = NUM_BINS * 100;
  localparam int unsigned LHS_W = W + $clog2(LHS_SCALE + 1);
  localparam int unsigned EDGE_W = CNT_W + 1 + eqtt_pkg::EDGE_SHIFT;
  localparam int unsigned CMP_W = (LHS_W > EDGE_W) ? LHS_W : EDGE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [W-1:0] gain_reg_q, init_reg_q, target_reg_q;
  logic [W-1:0] gain, fill_val;
  logic         cfg_wr;

  logic              mode_init_q;
  logic [LHS_W-1:0]  lhs_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              in_acc;
  logic              pass_last;

  logic                 out_valid_q;
  logic [CNT_W-1:0]     out_bin_q;
  logic [eqtt_pkg::THR_W-1:0] out_thr_q;
  logic                 out_load;

  eqtt_pkg::cell_ctrl_t cell_ctrl;
  eqtt_pkg::upd_ctrl_t  upd_ctrl;
  logic [W-1:0]         est [NUM_BINS];
  logic [W-1:0]         est_head;
  logic [EDGE_W-1:0]    edge_val;
  logic                 srch_found;
  logic [CNT_W-1:0]     srch_bin;
  logic [eqtt_pkg::THR_W-1:0] srch_thr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_reg_q   <= 17'd655;
      init_reg_q   <= 17'd3277;
      target_reg_q <= 17'd328;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        eqtt_pkg::REG_GAIN:   gain_reg_q   <= pwdata[W-1:0];
        eqtt_pkg::REG_INIT:   init_reg_q   <= pwdata[W-1:0];
        eqtt_pkg::REG_TARGET: target_reg_q <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      eqtt_pkg::REG_GAIN:   prdata = eqtt_pkg::DATA_W'(gain_reg_q);
      eqtt_pkg::REG_INIT:   prdata = eqtt_pkg::DATA_W'(init_reg_q);
      eqtt_pkg::REG_TARGET: prdata = eqtt_pkg::DATA_W'(target_reg_q);
      default:              prdata = '0;
    endcase
  end

  always_comb begin
    gain = gain_reg_q;
    if (gain_reg_q == '0) begin
      gain = W'(1);
    end else if (gain_reg_q > eqtt_pkg::Q16_ONE) begin
      gain = eqtt_pkg::Q16_ONE;
    end
    fill_val = (init_reg_q > eqtt_pkg::Q16_ONE) ? eqtt_pkg::Q16_ONE : init_reg_q;
  end

  // item control
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign pass_last  = (cnt_q == CNT_W'(NUM_BINS));
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        if (pass_last) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_init_q <= cmd_i;
      lhs_q       <= LHS_W'(sample_q16_i) * LHS_W'(LHS_SCALE);
    end
  end

  // ring of bins, tail cell holds the next bin to update
  assign cell_ctrl.fill  = in_acc && cmd_i;
  assign cell_ctrl.shift = (state_q == ST_RUN);

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
    if (i == 0) begin : g_head
      eqtt_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .fill_i (fill_val),
        .est_i  (est_head),
        .est_o  (est[i])
      );
    end else begin : g_body
      eqtt_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (cell_ctrl),
        .fill_i (fill_val),
        .est_i  (est[i-1]),
        .est_o  (est[i])
      );
    end
  end

  assign edge_val = {(CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(1),
                     eqtt_pkg::EDGE_SHIFT'(0)};

  assign upd_ctrl.start      = in_acc;
  assign upd_ctrl.shift      = (state_q == ST_RUN);
  assign upd_ctrl.slot_valid = !pass_last;
  assign upd_ctrl.decay      = CMP_W'(lhs_q) > CMP_W'(edge_val);
  assign upd_ctrl.hold       = mode_init_q;

  eqtt_update #(
    .NUM_BINS (NUM_BINS)
  ) u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (upd_ctrl),
    .bin_i    (cnt_q),
    .est_i    (est[NUM_BINS-1]),
    .gain_i   (gain),
    .target_i (target_reg_q),
    .est_o    (est_head),
    .found_o  (srch_found),
    .bin_o    (srch_bin),
    .thr_o    (srch_thr)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bin_q <= srch_bin;
      out_thr_q <= srch_thr;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign threshold_bin_o = eqtt_pkg::BIN_OUT_W'(out_bin_q);
  assign threshold_q16_o = out_thr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= CNT_W'(NUM_BINS)))
    else $error("ring pass counter ran past the bin count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN) && (cnt_q == '0))
    else $error("accepted item did not start a ring pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result shown without a finished pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && !srch_found |-> (srch_bin == CNT_W'(NUM_BINS)))
    else $error("search miss does not report the bin count");

endmodule

`default_nettype wire
